/* src/favored_kind_priority_queue_core_assert.svh */
// ============================================================================
// Assertion macros for the favored-kind priority queue
// Shorthand for clocked assertions that are disabled during reset.
// ============================================================================
`ifndef FAVORED_KIND_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define FAVORED_KIND_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge.
`define FKPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge.
`define FKPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fkpq_pkg.sv */
// ============================================================================
// Favored-kind priority queue package
// Shared types, depth constants and operation codes.
// ============================================================================
package fkpq_pkg;

    // Queue depth and the widths that follow from it.
    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Operation codes of the request beat.
    typedef enum logic [2:0] {
        FUNC_ENQUEUE = 3'd0,
        FUNC_DRAIN   = 3'd1,
        FUNC_REMOVE  = 3'd2,
        FUNC_QUERY   = 3'd3,
        FUNC_SET_FAV = 3'd4
    } func_t;

    // Control states of the sequencer.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // What the cell row does in one cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_FIND   = 2'd3
    } cell_op_t;

    // One stored queue entry.
    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] prio;
    } entry_t;

    // Command broadcast to every cell.
    typedef struct packed {
        cell_op_t   op;
        logic       match_any;
        logic [3:0] key_kind;
        entry_t     new_entry;
    } cell_cmd_t;

    // Request beat.
    typedef struct packed {
        logic [2:0] func;
        logic [3:0] kind;
        logic [3:0] priority_req;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic [3:0] out_kind;
        logic       emitted;
        logic       last;
        logic       found;
        logic       dropped;
        logic [4:0] occupancy;
    } rsp_t;

endpackage

/* src/fkpq_cell.sv */
// ============================================================================
// Queue cell
// Holds one entry and takes part in the insert, remove and search ripple.
// ============================================================================
module fkpq_cell (
    input  logic              clk,
    input  fkpq_pkg::cell_cmd_t cmd,
    input  logic              occupied,
    input  logic              at_tail,
    input  fkpq_pkg::entry_t  left_data,
    input  fkpq_pkg::entry_t  right_data,
    input  logic              hit_in,
    input  logic [3:0]        sel_kind_in,
    output fkpq_pkg::entry_t  data,
    output logic              hit_out,
    output logic [3:0]        sel_kind_out
);

    fkpq_pkg::entry_t data_reg;
    fkpq_pkg::entry_t data_next;
    logic             kind_match;
    logic             ins_hit;
    logic             hit_here;
    logic             mark;

    // Local compare for this cell's entry.
    always_comb
    begin
        kind_match = occupied && (cmd.match_any || (data_reg.kind == cmd.key_kind));
        ins_hit    = (occupied && (cmd.new_entry.prio > data_reg.prio)) || at_tail;
        case (cmd.op)
            fkpq_pkg::CELL_INSERT: hit_here = ins_hit;
            fkpq_pkg::CELL_REMOVE,
            fkpq_pkg::CELL_FIND:   hit_here = kind_match;
            default:               hit_here = 1'b0;
        endcase
        mark         = hit_here && !hit_in;
        hit_out      = hit_in || hit_here;
        sel_kind_out = mark ? data_reg.kind : sel_kind_in;
    end

    // Shift toward the tail on insert, toward the head on remove.
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            fkpq_pkg::CELL_INSERT:
            begin
                if (hit_in)
                    data_next = left_data;
                else if (mark)
                    data_next = cmd.new_entry;
            end
            fkpq_pkg::CELL_REMOVE:
            begin
                if (hit_in || mark)
                    data_next = right_data;
            end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* src/favored_kind_priority_queue_core.sv */
// ============================================================================
// Favored-kind priority queue core
// Stable priority queue built as a row of cells, with a favored-kind drain.
// ============================================================================
// A request beat is taken when start is high and busy is low; busy then stays
// high until the operation's last result has been produced. Results appear on
// result for one cycle each, marked by strobe, and cannot be held off, so the
// receiver must take every beat as it comes. Enqueue, query, set favored and
// unused codes give their single result from the execute state through the
// result register. Remove gives its single result once no matching entry is
// left, since the cell row deletes one matching entry per cycle. A drain emits
// one entry per cycle, with a pause without a result where the favored pass
// ends and entries remain. The configuration port holds jukebox_kind at byte
// address zero.
// ============================================================================
module favored_kind_priority_queue_core (
    input  logic          clk,
    input  logic          rst_n,
    // Request channel
    input  logic          start,
    input  fkpq_pkg::req_t req,
    output logic          busy,
    // Result channel
    output logic          strobe,
    output fkpq_pkg::rsp_t result,
    // Configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int D = fkpq_pkg::QUEUE_DEPTH;
    localparam int W = fkpq_pkg::COUNT_W;

    fkpq_pkg::state_t    state_reg, state_next;
    fkpq_pkg::req_t      req_reg, req_next;
    logic                head_phase_reg, head_phase_next;
    logic [W-1:0]        count_reg, count_next;
    logic [3:0]          favored_reg, favored_next;
    logic [3:0]          jukebox_reg;
    logic                strobe_reg, strobe_next;
    fkpq_pkg::rsp_t      result_reg, result_next;
    fkpq_pkg::cell_cmd_t cmd;

    fkpq_pkg::entry_t    cell_data [D];
    logic [D:0]          hit_chain;
    logic [3:0]          sel_chain [D+1];
    logic                accept;
    logic                any_hit;
    logic [3:0]          sel_kind;

    assign accept   = start && (state_reg == fkpq_pkg::S_IDLE);
    assign busy     = (state_reg != fkpq_pkg::S_IDLE);
    assign any_hit  = hit_chain[D];
    assign sel_kind = sel_chain[D];

    // Row of cells with the search ripple passed from head to tail.
    assign hit_chain[0] = 1'b0;
    assign sel_chain[0] = 4'd0;

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        fkpq_pkg::entry_t left_d;
        fkpq_pkg::entry_t right_d;
        logic             occ;
        logic             tail;

        assign occ  = (W'(i) < count_reg);
        assign tail = (W'(i) == count_reg);

        if (i == 0)
        begin : g_head
            assign left_d = cmd.new_entry;
        end
        else
        begin : g_inner
            assign left_d = cell_data[i-1];
        end

        if (i == D - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid
            assign right_d = cell_data[i+1];
        end

        fkpq_cell u_cell (
            .clk          (clk),
            .cmd          (cmd),
            .occupied     (occ),
            .at_tail      (tail),
            .left_data    (left_d),
            .right_data   (right_d),
            .hit_in       (hit_chain[i]),
            .sel_kind_in  (sel_chain[i]),
            .data         (cell_data[i]),
            .hit_out      (hit_chain[i+1]),
            .sel_kind_out (sel_chain[i+1])
        );
    end

    // Sequencer state and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fkpq_pkg::S_IDLE;
            head_phase_reg <= 1'b0;
            count_reg      <= '0;
            favored_reg    <= 4'd0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_phase_reg <= head_phase_next;
            count_reg      <= count_next;
            favored_reg    <= favored_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    // Next state, cell command and result beat.
    always_comb
    begin
        state_next         = state_reg;
        req_next           = req_reg;
        head_phase_next    = head_phase_reg;
        count_next         = count_reg;
        favored_next       = favored_reg;
        strobe_next        = 1'b0;
        result_next        = result_reg;
        cmd.op             = fkpq_pkg::CELL_HOLD;
        cmd.match_any      = 1'b0;
        cmd.key_kind       = req_reg.kind;
        cmd.new_entry.kind = req_reg.kind;
        cmd.new_entry.prio = req_reg.priority_req;

        unique case (state_reg)
            fkpq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = req;
                    head_phase_next = 1'b0;
                    state_next      = fkpq_pkg::S_EXEC;
                end
            end
            fkpq_pkg::S_EXEC:
            begin
                // Default single closing beat.
                result_next           = '0;
                result_next.last      = 1'b1;
                result_next.occupancy = 5'(count_reg);
                unique case (req_reg.func)
                    fkpq_pkg::FUNC_ENQUEUE:
                    begin
                        strobe_next = 1'b1;
                        state_next  = fkpq_pkg::S_IDLE;
                        if (count_reg == W'(D))
                        begin
                            result_next.dropped = 1'b1;
                        end
                        else
                        begin
                            cmd.op                = fkpq_pkg::CELL_INSERT;
                            count_next            = count_reg + W'(1);
                            result_next.occupancy = 5'(count_next);
                        end
                    end
                    fkpq_pkg::FUNC_DRAIN:
                    begin
                        cmd.op        = fkpq_pkg::CELL_REMOVE;
                        cmd.match_any = head_phase_reg;
                        cmd.key_kind  = favored_reg;
                        if (count_reg == '0)
                        begin
                            strobe_next = 1'b1;
                            state_next  = fkpq_pkg::S_IDLE;
                        end
                        else if (any_hit)
                        begin
                            count_next            = count_reg - W'(1);
                            strobe_next           = 1'b1;
                            result_next.out_kind  = sel_kind;
                            result_next.emitted   = 1'b1;
                            result_next.last      = (count_next == '0);
                            result_next.occupancy = 5'(count_next);
                            if (sel_kind == jukebox_reg)
                                favored_next = jukebox_reg;
                            if (count_next == '0)
                                state_next = fkpq_pkg::S_IDLE;
                        end
                        else
                        begin
                            // Favored pass found nothing: go on from the head.
                            head_phase_next = 1'b1;
                        end
                    end
                    fkpq_pkg::FUNC_REMOVE:
                    begin
                        cmd.op = fkpq_pkg::CELL_REMOVE;
                        if (any_hit)
                        begin
                            count_next = count_reg - W'(1);
                        end
                        else
                        begin
                            strobe_next = 1'b1;
                            state_next  = fkpq_pkg::S_IDLE;
                        end
                    end
                    fkpq_pkg::FUNC_QUERY:
                    begin
                        cmd.op            = fkpq_pkg::CELL_FIND;
                        result_next.found = any_hit;
                        strobe_next       = 1'b1;
                        state_next        = fkpq_pkg::S_IDLE;
                    end
                    fkpq_pkg::FUNC_SET_FAV:
                    begin
                        favored_next = req_reg.kind;
                        strobe_next  = 1'b1;
                        state_next   = fkpq_pkg::S_IDLE;
                    end
                    default:
                    begin
                        strobe_next = 1'b1;
                        state_next  = fkpq_pkg::S_IDLE;
                    end
                endcase
            end
            default:
                state_next = fkpq_pkg::S_IDLE;
        endcase
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // Configuration register: jukebox kind at word zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            jukebox_reg <= 4'd0;
        else if (psel && penable && pwrite && pready && !paddr[2])
            jukebox_reg <= pwdata[3:0];
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {28'd0, jukebox_reg};

    // Checks on the sequencer and the count.
`include "favored_kind_priority_queue_core_assert.svh"

    `FKPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= W'(D), "entry count above depth")
    `FKPQ_ASSERT_NOW(a_strobe_after_exec, strobe, $past(state_reg) == fkpq_pkg::S_EXEC, "result without work")
    `FKPQ_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
    `FKPQ_ASSERT_NOW(a_last_empty, strobe && result.emitted && result.last, result.occupancy == 5'd0, "drain ended with entries left")

endmodule
